// ===== rtl/core/lsi_pkg.sv =====
`default_nettype none

package lsi_pkg;

    localparam int LSI_MAX_LINES = 1024;
    localparam int LSI_OFF_W     = 24;
    localparam int LSI_LINE_W    = 10;
    localparam int LSI_TOTAL_W   = 11;
    localparam int LSI_OP_W      = 3;
    localparam int LSI_ST_W      = 2;

    localparam logic [7:0] LSI_NEWLINE = 8'h0A;

    localparam logic [LSI_OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [LSI_OP_W-1:0] OP_TEXT  = 3'd1;
    localparam logic [LSI_OP_W-1:0] OP_END   = 3'd2;
    localparam logic [LSI_OP_W-1:0] OP_LOOK  = 3'd3;
    localparam logic [LSI_OP_W-1:0] OP_POS   = 3'd4;
    localparam logic [LSI_OP_W-1:0] OP_DEL   = 3'd5;

    localparam logic [LSI_ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [LSI_ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [LSI_ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [LSI_ST_W-1:0] ST_EMPTY = 2'd3;

    typedef logic [LSI_OFF_W-1:0] t_off;

    function automatic t_off sat_add(input t_off a, input t_off b);
        logic [LSI_OFF_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LSI_OFF_W] ? '1 : s[LSI_OFF_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lsi_ram.sv =====
`default_nettype none

module lsi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/line_start_index_table.sv =====
// Line start index table. Text bytes, clear and end requests are handled in the idle
// state, so a byte stream runs at one byte per cycle while the result side keeps up. An
// offset lookup scans the table from line 0 through one shared add/subtract unit,
// reading and comparing each line visited. A position lookup reads the line's start and
// adds the column. A delete copies every later line down one entry through the table
// memory's separate read and write ports, reading then writing each moved line. Every
// request returns one result; the input is stalled while a lookup or delete runs.
`default_nettype none

module line_start_index_table
    import lsi_pkg::*;
#(
    parameter int MAX_LINES = LSI_MAX_LINES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [LSI_OP_W-1:0]    i_op,
    input  wire logic [7:0]             i_text_byte,
    input  wire logic [LSI_OFF_W-1:0]   i_query_offset,
    input  wire logic [LSI_LINE_W-1:0]  i_query_line,
    input  wire logic [LSI_OFF_W-1:0]   i_query_column,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [LSI_ST_W-1:0]         o_status,
    output logic [LSI_LINE_W-1:0]       o_found_line,
    output logic [LSI_OFF_W-1:0]        o_found_column,
    output logic [LSI_OFF_W-1:0]        o_found_offset,
    output logic [LSI_OFF_W-1:0]        o_found_length,
    output logic [LSI_TOTAL_W-1:0]      o_line_total
);

    localparam int IDX_W = $clog2(MAX_LINES);
    localparam int CNT_W = $clog2(MAX_LINES + 1);
    localparam int CMP_W = (CNT_W > LSI_LINE_W) ? CNT_W : LSI_LINE_W;
    localparam int RAM_W = 2 * LSI_OFF_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LRD  = 9'b000000010,
        S_LCMP = 9'b000000100,
        S_LCOL = 9'b000001000,
        S_PRD  = 9'b000010000,
        S_PADD = 9'b000100000,
        S_DRD  = 9'b001000000,
        S_DWR  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_off r_run, n_run, r_cur, n_cur;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_off r_q_off, n_q_off, r_q_col, n_q_col, r_pstart, n_pstart;
    logic [LSI_ST_W-1:0] r_st, n_st;
    logic [LSI_LINE_W-1:0] r_fl, n_fl;
    t_off r_fc, n_fc, r_fo, n_fo, r_flen, n_flen;

    logic r_ovalid;
    logic [LSI_ST_W-1:0] r_o_status;
    logic [LSI_LINE_W-1:0] r_o_line;
    t_off r_o_col, r_o_off, r_o_len;
    logic [LSI_TOTAL_W-1:0] r_o_total;

    logic accept, out_free, out_load;
    logic [LSI_ST_W-1:0] out_st;
    logic [LSI_LINE_W-1:0] out_fl;
    t_off out_fc, out_fo, out_flen;

    logic close_en;
    t_off close_len, cur_inc;
    logic q_oor;
    logic [CNT_W-1:0] idx_inc;

    logic ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [RAM_W-1:0] ram_wdata, ram_rdata;
    t_off rd_start, rd_len;

    t_off alu_a, alu_b;
    logic alu_sub;
    logic [LSI_OFF_W:0] alu_sum;
    logic alu_borrow;
    t_off alu_sat;

    lsi_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_LINES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[RAM_W-1:LSI_OFF_W];
    assign rd_len   = ram_rdata[LSI_OFF_W-1:0];

    assign o_stall  = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    assign idx_inc   = CNT_W'(r_idx) + CNT_W'(1);
    assign ram_raddr = (r_state == S_DRD) ? IDX_W'(idx_inc) : r_idx;
    assign cur_inc   = sat_add(r_cur, t_off'(1));
    assign q_oor     = CMP_W'(i_query_line) >= CMP_W'(r_count);

    always_comb begin
        unique case (r_state)
            S_PADD: begin
                alu_a   = rd_start;
                alu_b   = r_q_col;
                alu_sub = 1'b0;
            end
            S_LCOL: begin
                alu_a   = r_q_off;
                alu_b   = r_pstart;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = r_q_off;
                alu_b   = rd_start;
                alu_sub = 1'b1;
            end
        endcase
        alu_sum    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
        alu_borrow = alu_sum[LSI_OFF_W];
        alu_sat    = alu_sum[LSI_OFF_W] ? '1 : alu_sum[LSI_OFF_W-1:0];
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_run    = r_run;
        n_cur    = r_cur;
        n_idx    = r_idx;
        n_q_off  = r_q_off;
        n_q_col  = r_q_col;
        n_pstart = r_pstart;
        n_st     = r_st;
        n_fl     = r_fl;
        n_fc     = r_fc;
        n_fo     = r_fo;
        n_flen   = r_flen;
        close_en  = 1'b0;
        close_len = r_cur;
        ram_we    = 1'b0;
        ram_waddr = IDX_W'(r_count);
        ram_wdata = {r_run, r_cur};
        out_load  = 1'b0;
        out_st    = ST_OK;
        out_fl    = '0;
        out_fc    = '0;
        out_fo    = '0;
        out_flen  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    out_load = 1'b1;
                    n_st     = ST_OK;
                    n_fl     = '0;
                    n_fc     = '0;
                    n_fo     = '0;
                    n_flen   = '0;
                    unique case (i_op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_run   = '0;
                            n_cur   = '0;
                        end
                        OP_TEXT: begin
                            if (i_text_byte == LSI_NEWLINE) begin
                                close_en  = 1'b1;
                                close_len = cur_inc;
                            end else begin
                                n_cur = cur_inc;
                            end
                        end
                        OP_END: begin
                            close_en = (r_cur != '0);
                        end
                        OP_LOOK: begin
                            if (r_count == '0) begin
                                out_st = ST_EMPTY;
                            end else begin
                                out_load = 1'b0;
                                n_q_off  = i_query_offset;
                                n_idx    = '0;
                                n_state  = S_LRD;
                            end
                        end
                        OP_POS: begin
                            if (r_count == '0) begin
                                out_st = ST_EMPTY;
                            end else if (q_oor) begin
                                out_st = ST_RANGE;
                            end else begin
                                out_load = 1'b0;
                                n_idx    = IDX_W'(i_query_line);
                                n_q_col  = i_query_column;
                                n_fl     = i_query_line;
                                n_fc     = i_query_column;
                                n_state  = S_PRD;
                            end
                        end
                        OP_DEL: begin
                            if (r_count == '0) begin
                                out_st = ST_EMPTY;
                            end else if (q_oor) begin
                                out_st = ST_RANGE;
                            end else begin
                                out_load = 1'b0;
                                n_idx    = IDX_W'(i_query_line);
                                n_fl     = i_query_line;
                                n_state  = S_DRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (close_en) begin
                        if (r_count == CNT_W'(MAX_LINES)) begin
                            out_st = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {r_run, close_len};
                            n_count   = r_count + CNT_W'(1);
                        end
                        n_run = sat_add(r_run, close_len);
                        n_cur = '0;
                    end
                end
            end
            S_LRD: begin
                n_state = S_LCMP;
            end
            S_LCMP: begin
                if ((r_idx != '0) && alu_borrow) begin
                    n_state = S_LCOL;
                end else begin
                    n_pstart = rd_start;
                    n_flen   = rd_len;
                    n_fl     = LSI_LINE_W'(r_idx);
                    if (idx_inc == r_count) begin
                        n_state = S_LCOL;
                    end else begin
                        n_idx   = IDX_W'(idx_inc);
                        n_state = S_LRD;
                    end
                end
            end
            S_LCOL: begin
                n_fc    = alu_borrow ? '0 : alu_sum[LSI_OFF_W-1:0];
                n_state = S_DONE;
            end
            S_PRD: begin
                n_state = S_PADD;
            end
            S_PADD: begin
                n_fo    = alu_sat;
                n_flen  = rd_len;
                n_state = S_DONE;
            end
            S_DRD: begin
                if (idx_inc < r_count) begin
                    n_state = S_DWR;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                n_idx     = IDX_W'(idx_inc);
                n_state   = S_DRD;
            end
            S_DONE: begin
                out_st   = r_st;
                out_fl   = r_fl;
                out_fc   = r_fc;
                out_fo   = r_fo;
                out_flen = r_flen;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_run    <= '0;
            r_cur    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_run   <= n_run;
            r_cur   <= n_cur;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_q_off  <= n_q_off;
        r_q_col  <= n_q_col;
        r_pstart <= n_pstart;
        r_st     <= n_st;
        r_fl     <= n_fl;
        r_fc     <= n_fc;
        r_fo     <= n_fo;
        r_flen   <= n_flen;
        if (out_load) begin
            r_o_status <= out_st;
            r_o_line   <= out_fl;
            r_o_col    <= out_fc;
            r_o_off    <= out_fo;
            r_o_len    <= out_flen;
            r_o_total  <= LSI_TOTAL_W'(n_count);
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_o_status;
    assign o_found_line   = r_o_line;
    assign o_found_column = r_o_col;
    assign o_found_offset = r_o_off;
    assign o_found_length = r_o_len;
    assign o_line_total   = r_o_total;

endmodule

`default_nettype wire

// ===== rtl/core/lsi_checker.sv =====
`default_nettype none

module lsi_assertions
    import lsi_pkg::*;
#(
    parameter int MAX_LINES = LSI_MAX_LINES
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_valid,
    input wire logic                   o_stall,
    input wire logic [LSI_OP_W-1:0]    i_op,
    input wire logic [7:0]             i_text_byte,
    input wire logic [LSI_OFF_W-1:0]   i_query_offset,
    input wire logic [LSI_LINE_W-1:0]  i_query_line,
    input wire logic [LSI_OFF_W-1:0]   i_query_column,
    input wire logic                   o_valid,
    input wire logic                   i_stall,
    input wire logic [LSI_ST_W-1:0]    o_status,
    input wire logic [LSI_LINE_W-1:0]  o_found_line,
    input wire logic [LSI_OFF_W-1:0]   o_found_column,
    input wire logic [LSI_OFF_W-1:0]   o_found_offset,
    input wire logic [LSI_OFF_W-1:0]   o_found_length,
    input wire logic [LSI_TOTAL_W-1:0] o_line_total
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_status) && $stable(o_found_offset)
            && $stable(o_line_total))
        else $error("stalled result changed");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> o_line_total == LSI_TOTAL_W'(MAX_LINES))
        else $error("table full reported below capacity");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_line_total == '0) && (o_found_line == '0)
            && (o_found_length == '0))
        else $error("empty status with lines present or fields set");

    a_range_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_RANGE) |-> (o_found_column == '0)
            && (o_found_offset == '0) && (o_found_length == '0))
        else $error("range error carries lookup data");

endmodule

bind line_start_index_table lsi_assertions #(.MAX_LINES(MAX_LINES)) u_lsi_assertions (.*);

`default_nettype wire
